// File: rtl/kdop_pkg.sv
// ----------------------------------------------------------------------------
// kdop_pkg
// Shared types and constants for the k-DOP18 bounding volume unit.
// ----------------------------------------------------------------------------
package kdop_pkg;

  // Axis order: x, y, z, x+y, x+z, y+z, x-y, x-z, y-z
  localparam int AXES    = 9;
  localparam int THICK_W = 31;
  localparam int DIAG_W  = 32;  // round(thickness * sqrt2) fits in 32 bits
  localparam int PROD_W  = 62;

  // sqrt2 as unsigned Q1.30
  localparam logic [THICK_W-1:0] SQRT2_Q30  = 31'd1518500250;
  localparam logic [PROD_W-1:0]  ROUND_HALF = 62'd536870912;  // 2^29

  typedef enum logic [2:0] {
    OP_CLEAR   = 3'd0,
    OP_ADD     = 3'd1,
    OP_MERGE   = 3'd2,
    OP_OVERLAP = 3'd3,
    OP_INSIDE  = 3'd4,
    OP_SPLIT   = 3'd5
  } op_e;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

endpackage

// File: rtl/kdop_project.sv
// ----------------------------------------------------------------------------
// kdop_project
// Projects a point onto the nine k-DOP18 axes at bound width.
// ----------------------------------------------------------------------------
module kdop_project
  import kdop_pkg::*;
#(
  parameter int CW = 32,
  parameter int BW = 34
) (
  input  logic signed [CW-1:0] px_i,
  input  logic signed [CW-1:0] py_i,
  input  logic signed [CW-1:0] pz_i,
  output logic signed [BW-1:0] proj_o [AXES]
);

  logic signed [BW-1:0] x, y, z;

  assign x = BW'(px_i);
  assign y = BW'(py_i);
  assign z = BW'(pz_i);

  assign proj_o[0] = x;
  assign proj_o[1] = y;
  assign proj_o[2] = z;
  assign proj_o[3] = x + y;
  assign proj_o[4] = x + z;
  assign proj_o[5] = y + z;
  assign proj_o[6] = x - y;
  assign proj_o[7] = x - z;
  assign proj_o[8] = y - z;

endmodule

// File: rtl/kdop_overlap.sv
// ----------------------------------------------------------------------------
// kdop_overlap
// Overlap test of the first box against the second box widened by thickness.
// ----------------------------------------------------------------------------
module kdop_overlap
  import kdop_pkg::*;
#(
  parameter int BW = 34
) (
  input  logic signed [BW-1:0]      a_min_i [AXES],
  input  logic signed [BW-1:0]      a_max_i [AXES],
  input  logic signed [BW-1:0]      b_min_i [AXES],
  input  logic signed [BW-1:0]      b_max_i [AXES],
  input  logic        [THICK_W-1:0] thick_i,
  input  logic        [DIAG_W-1:0]  diag_i,
  output logic                      hit_o
);

  // Wide enough for bound +/- widening without overflow. Saturating the
  // widened bound to bound range gives the same compare outcome, since the
  // first box's bounds always lie inside that range.
  localparam int EW = ((BW > DIAG_W + 1) ? BW : DIAG_W + 1) + 1;

  logic signed [EW-1:0] lo [AXES];
  logic signed [EW-1:0] hi [AXES];
  logic signed [EW-1:0] w  [AXES];
  logic [AXES-1:0]      sep;

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      w[i]   = (i < 3) ? $signed(EW'(thick_i)) : $signed(EW'(diag_i));
      lo[i]  = EW'(b_min_i[i]) - w[i];
      hi[i]  = EW'(b_max_i[i]) + w[i];
      sep[i] = (EW'(a_min_i[i]) > hi[i]) || (EW'(a_max_i[i]) < lo[i]);
    end
  end

  assign hit_o = ~|sep;

endmodule

// File: rtl/kdop_split.sv
// ----------------------------------------------------------------------------
// kdop_split
// Split axis (largest x/y/z extent) and floored centre on that axis, saturated to CW.
// ----------------------------------------------------------------------------
module kdop_split
  import kdop_pkg::*;
#(
  parameter int CW = 32,
  parameter int BW = 34
) (
  input  logic signed [BW-1:0] min_i [AXES],
  input  logic signed [BW-1:0] max_i [AXES],
  output logic        [1:0]    axis_o,
  output logic signed [CW-1:0] pos_o
);

  localparam logic signed [BW-1:0] C_HI = {{(BW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [BW-1:0] C_LO = {{(BW-CW+1){1'b1}}, {(CW-1){1'b0}}};

  logic signed [BW:0]   wx, wy, wz, sum;
  logic signed [BW-1:0] centre;

  assign wx = (BW+1)'(max_i[0]) - (BW+1)'(min_i[0]);
  assign wy = (BW+1)'(max_i[1]) - (BW+1)'(min_i[1]);
  assign wz = (BW+1)'(max_i[2]) - (BW+1)'(min_i[2]);

  always_comb begin
    priority if (wx >= wy && wx >= wz) begin
      axis_o = AXIS_X;
      sum    = (BW+1)'(min_i[0]) + (BW+1)'(max_i[0]);
    end else if (wy >= wz) begin
      axis_o = AXIS_Y;
      sum    = (BW+1)'(min_i[1]) + (BW+1)'(max_i[1]);
    end else begin
      axis_o = AXIS_Z;
      sum    = (BW+1)'(min_i[2]) + (BW+1)'(max_i[2]);
    end
    centre = sum[BW:1];  // floor(sum / 2)
    priority if (centre > C_HI) begin
      pos_o = C_HI[CW-1:0];
    end else if (centre < C_LO) begin
      pos_o = C_LO[CW-1:0];
    end else begin
      pos_o = centre[CW-1:0];
    end
  end

endmodule

// File: rtl/kdop18_bounding_volume_unit_core.sv
// ----------------------------------------------------------------------------
// kdop18_bounding_volume_unit_core
// Two k-DOP18 boxes with clear, add, merge, overlap, inside and split ops.
// ----------------------------------------------------------------------------
// Pipeline: input register, then result register. The input register loads
//   at the accept edge; one pass of compare/update logic feeds the result
//   register, which loads when m_axis can advance.
// Throughput: one item per cycle while m_axis is not stalled; box state is
//   written when the result register loads, so the next item sees it.
// Reset: both boxes empty (minima most positive, maxima most negative),
//   thickness 0, no result pending.
module kdop18_bounding_volume_unit_core
  import kdop_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  localparam int BW     = COORD_WIDTH + 2,
  localparam int IN_TW  = ((3 * COORD_WIDTH + 7) / 8) * 8,
  localparam int OUT_TW = ((COORD_WIDTH + 3 + 7) / 8) * 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [IN_TW-1:0]    s_axis_tdata,   // point_x, point_y, point_z
  input  logic [3:0]          s_axis_tuser,   // operation[2:0], box_select
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OUT_TW-1:0]   m_axis_tdata,   // hit, split_axis, split_position
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [THICK_W-1:0]  cfg_data_i      // thickness
);

  localparam logic signed [BW-1:0] B_HI = {1'b0, {(BW-1){1'b1}}};
  localparam logic signed [BW-1:0] B_LO = {1'b1, {(BW-1){1'b0}}};

  // Configuration; the diagonal widening is computed once at write time
  logic [THICK_W-1:0] thick_q;
  logic [DIAG_W-1:0]  diag_q;
  logic [PROD_W-1:0]  diag_prod;
  logic [PROD_W-1:0]  diag_sum;

  assign cfg_ready_o = 1'b1;
  assign diag_prod   = PROD_W'(cfg_data_i) * PROD_W'(SQRT2_Q30);
  assign diag_sum    = diag_prod + ROUND_HALF;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thick_q <= '0;
      diag_q  <= '0;
    end else if (cfg_valid_i) begin
      thick_q <= cfg_data_i;
      diag_q  <= diag_sum[PROD_W-1:PROD_W-DIAG_W];
    end
  end

  // Input register
  logic                          s1_valid_q;
  logic [2:0]                    s1_op_q;
  logic                          s1_sel_q;
  logic signed [COORD_WIDTH-1:0] s1_x_q, s1_y_q, s1_z_q;
  logic                          advance;
  logic                          in_fire;
  logic                          work;

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || advance;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign work          = s1_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q  <= s_axis_tuser[2:0];
      s1_sel_q <= s_axis_tuser[3];
      s1_x_q   <= s_axis_tdata[COORD_WIDTH-1:0];
      s1_y_q   <= s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
      s1_z_q   <= s_axis_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];
    end
  end

  // Box state
  logic signed [BW-1:0] a_min_q [AXES], a_max_q [AXES];
  logic signed [BW-1:0] b_min_q [AXES], b_max_q [AXES];
  logic signed [BW-1:0] a_min_d [AXES], a_max_d [AXES];
  logic signed [BW-1:0] b_min_d [AXES], b_max_d [AXES];
  logic signed [BW-1:0] sel_min [AXES], sel_max [AXES];
  logic signed [BW-1:0] proj    [AXES];

  kdop_project #(.CW(COORD_WIDTH), .BW(BW)) u_project (
    .px_i   (s1_x_q),
    .py_i   (s1_y_q),
    .pz_i   (s1_z_q),
    .proj_o (proj)
  );

  logic                          overlap_hit;
  logic [1:0]                    split_axis;
  logic signed [COORD_WIDTH-1:0] split_pos;
  logic [AXES-1:0]               outside;

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      sel_min[i] = s1_sel_q ? b_min_q[i] : a_min_q[i];
      sel_max[i] = s1_sel_q ? b_max_q[i] : a_max_q[i];
      outside[i] = (proj[i] < sel_min[i]) || (proj[i] > sel_max[i]);
    end
  end

  kdop_overlap #(.BW(BW)) u_overlap (
    .a_min_i (a_min_q),
    .a_max_i (a_max_q),
    .b_min_i (b_min_q),
    .b_max_i (b_max_q),
    .thick_i (thick_q),
    .diag_i  (diag_q),
    .hit_o   (overlap_hit)
  );

  kdop_split #(.CW(COORD_WIDTH), .BW(BW)) u_split (
    .min_i  (sel_min),
    .max_i  (sel_max),
    .axis_o (split_axis),
    .pos_o  (split_pos)
  );

  // Next box state and result
  logic                          hit_d;
  logic [1:0]                    axis_d;
  logic signed [COORD_WIDTH-1:0] pos_d;

  always_comb begin
    a_min_d = a_min_q;
    a_max_d = a_max_q;
    b_min_d = b_min_q;
    b_max_d = b_max_q;
    hit_d   = 1'b0;
    axis_d  = AXIS_X;
    pos_d   = '0;
    case (op_e'(s1_op_q))
      OP_CLEAR: begin
        for (int i = 0; i < AXES; i++) begin
          if (s1_sel_q) begin
            b_min_d[i] = B_HI;
            b_max_d[i] = B_LO;
          end else begin
            a_min_d[i] = B_HI;
            a_max_d[i] = B_LO;
          end
        end
      end
      OP_ADD: begin
        for (int i = 0; i < AXES; i++) begin
          if (s1_sel_q) begin
            if (proj[i] < b_min_q[i]) b_min_d[i] = proj[i];
            if (proj[i] > b_max_q[i]) b_max_d[i] = proj[i];
          end else begin
            if (proj[i] < a_min_q[i]) a_min_d[i] = proj[i];
            if (proj[i] > a_max_q[i]) a_max_d[i] = proj[i];
          end
        end
      end
      OP_MERGE: begin
        for (int i = 0; i < AXES; i++) begin
          if (b_min_q[i] < a_min_q[i]) a_min_d[i] = b_min_q[i];
          if (b_max_q[i] > a_max_q[i]) a_max_d[i] = b_max_q[i];
        end
      end
      OP_OVERLAP: hit_d = overlap_hit;
      OP_INSIDE:  hit_d = ~|outside;
      OP_SPLIT: begin
        axis_d = split_axis;
        pos_d  = split_pos;
      end
      default: ;  // unused codes: no change, zero result
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < AXES; i++) begin
        a_min_q[i] <= B_HI;
        a_max_q[i] <= B_LO;
        b_min_q[i] <= B_HI;
        b_max_q[i] <= B_LO;
      end
    end else if (work) begin
      a_min_q <= a_min_d;
      a_max_q <= a_max_d;
      b_min_q <= b_min_d;
      b_max_q <= b_max_d;
    end
  end

  // Result register
  logic                          out_hit_q;
  logic [1:0]                    out_axis_q;
  logic signed [COORD_WIDTH-1:0] out_pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (work) begin
      out_hit_q  <= hit_d;
      out_axis_q <= axis_d;
      out_pos_q  <= pos_d;
    end
  end

  assign m_axis_tdata = OUT_TW'({out_pos_q, out_axis_q, out_hit_q});

endmodule
